@@ rtl/csglu_pkg.sv @@
// ----------------------------------------------------------------------------
// csglu_pkg
// shared constants, register indexes and the sigmoid sample table for the
// clamped gated activation
// ----------------------------------------------------------------------------
package csglu_pkg;

	localparam int SIG_ENTRIES = 256;
	localparam int IDX_W       = $clog2(SIG_ENTRIES);
	localparam int RA_W        = $clog2(SIG_ENTRIES + 1);
	localparam int P_W         = 23 + IDX_W;
	localparam int CFG_ADDR_W  = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [15:0] ALPHA_RST = 16'd6971;
	localparam logic [14:0] LIMIT_RST = 15'd1792;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ALPHA = 1'b0,
		REG_LIMIT = 1'b1
	} cfg_reg_t;

	typedef logic [16:0] sig_rom_t [0:SIG_ENTRIES];

	// long division by shift and subtract, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-t by series and squaring, then 1/(1+e^-t), q0.16
	function automatic logic [16:0] sig_sample(input int unsigned i);
		logic [63:0] u;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] den;
		logic [63:0] q30;
		q30  = 64'd1 << 30;
		u    = (64'(i) << 29) >> IDX_W;
		sum  = q30;
		term = q30;
		for (int k = 1; k <= 16; k++) begin
			term = udiv64((term * u) >> 30, 64'(k));
			if ((k & 1) == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		for (int sq = 0; sq < 4; sq++)
			sum = (sum * sum) >> 30;
		den = q30 + sum;
		return 17'(udiv64((64'd1 << 46) + (den >> 1), den));
	endfunction

	function automatic sig_rom_t build_sig_rom();
		sig_rom_t r;
		for (int i = 0; i <= SIG_ENTRIES; i++)
			r[i] = sig_sample(i);
		return r;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

@@ rtl/clamped_swiglu_activation_top.sv @@
// ----------------------------------------------------------------------------
// clamped_swiglu_activation_top
// element-wise gated activation: x * sigmoid(alpha * x) * (y + 1) with
// clamped inputs, sigmoid from an interpolated table, q16.16 saturated result
// ----------------------------------------------------------------------------
//  channel   dir  word layout (lsb first)                    handshake
//  s_axis    in   tdata: gate_value[15:0], up_value[31:16]   tvalid/tready
//                 tlast: last_in
//  m_axis    out  tdata: activation[31:0]                    tvalid/tready
//                 tlast: last_out
//  cfg       in   cfg_addr 0 sigmoid_alpha, 1 clamp_limit     cfg_we
//
//  nine register stages, one word accepted per cycle unless a stall on m_axis fills the pipe
//  stage depth is set by the two multipliers in the product and the table
//  interpolation multiplier
//  each stage holds when the next one is full and stalled, so empty stages
//  keep filling while a result waits on m_axis
//  arst_n empties the pipe and restores both registers to their defaults
// ----------------------------------------------------------------------------
module clamped_swiglu_activation_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [31:0]                           s_axis_tdata,  // gate_value, up_value
	input  logic                                  s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [31:0]                           m_axis_tdata,  // activation
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_we,
	input  logic [csglu_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [csglu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import csglu_pkg::*;

	logic [15:0] alpha_q;
	logic [14:0] limit_q;

	logic [9:1]  vld;
	logic [9:1]  rdy;

	// stage 1
	logic signed [15:0] x_s1, y_s1;
	logic               last_s1;
	// stage 2
	logic signed [32:0] z_s2;
	logic signed [15:0] x_s2, y_s2;
	logic               last_s2;
	// stage 3
	logic [RA_W-1:0]    idx_s3;
	logic [22:0]        frac_s3;
	logic               neg_s3, sat_s3;
	logic signed [15:0] x_s3, y_s3;
	logic               last_s3;
	// stage 4
	logic [16:0]        r0_s4;
	logic signed [17:0] diff_s4;
	logic [22:0]        frac_s4;
	logic               neg_s4, sat_s4;
	logic signed [15:0] x_s4, y_s4;
	logic               last_s4;
	// stage 5
	logic [16:0]        mag_s5;
	logic               neg_s5, sat_s5;
	logic signed [15:0] x_s5, y_s5;
	logic               last_s5;
	// stage 6
	logic [16:0]        s_s6;
	logic signed [16:0] y1_s6;
	logic signed [15:0] x_s6;
	logic               last_s6;
	// stage 7
	logic signed [33:0] a_s7;
	logic signed [16:0] y1_s7;
	logic               last_s7;
	// stage 8
	logic signed [50:0] v_s8;
	logic               last_s8;
	// stage 9
	logic [31:0]        act_s9;
	logic               last_s9;

	// combinational
	logic signed [16:0] lim_c, xw_c, yw_c;
	logic signed [15:0] xc_c, yc_c;
	logic [32:0]        zmag_c;
	logic [P_W-1:0]     p_c;
	logic [RA_W-1:0]    idx1_c;
	logic signed [41:0] interp_c;
	logic [16:0]        spos_c;
	logic [50:0]        vmag_c;
	logic [34:0]        r_c;
	logic [31:0]        act_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_ALPHA: alpha_q <= cfg_wdata;
				REG_LIMIT: limit_q <= cfg_wdata[14:0];
				default:   ;
			endcase
		end
	end

	// stall chain
	assign rdy[9] = !vld[9] || m_axis_tready;
	genvar g;
	generate
		for (g = 1; g < 9; g++) begin : g_rdy
			assign rdy[g] = !vld[g] || rdy[g+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1])
				vld[1] <= s_axis_tvalid;
			for (int k = 2; k <= 9; k++)
				if (rdy[k])
					vld[k] <= vld[k-1];
		end
	end

	// clamp
	always_comb begin
		lim_c = $signed({2'b00, limit_q});
		xw_c  = 17'(signed'(s_axis_tdata[15:0]));
		yw_c  = 17'(signed'(s_axis_tdata[31:16]));
		xc_c  = (xw_c > lim_c) ? 16'(lim_c) : 16'(xw_c);
		if (yw_c > lim_c)
			yc_c = 16'(lim_c);
		else if (yw_c < -lim_c)
			yc_c = 16'(-lim_c);
		else
			yc_c = 16'(yw_c);
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			x_s1    <= xc_c;
			y_s1    <= yc_c;
			last_s1 <= s_axis_tlast;
		end
	end

	// slope product
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			z_s2    <= $signed({1'b0, alpha_q}) * x_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			last_s2 <= last_s1;
		end
	end

	// magnitude, saturation and table position
	always_comb begin
		zmag_c = z_s2[32] ? 33'(-z_s2) : 33'(z_s2);
		p_c    = P_W'(zmag_c[22:0]) * P_W'(SIG_ENTRIES);
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			idx_s3  <= RA_W'(p_c[P_W-1:23]);
			frac_s3 <= p_c[22:0];
			neg_s3  <= z_s2[32];
			sat_s3  <= (zmag_c[32:23] != '0);
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			last_s3 <= last_s2;
		end
	end

	// table read
	assign idx1_c = idx_s3 + RA_W'(1);

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			r0_s4   <= SIG_ROM[idx_s3];
			diff_s4 <= $signed({1'b0, SIG_ROM[idx1_c]}) - $signed({1'b0, SIG_ROM[idx_s3]});
			frac_s4 <= frac_s3;
			neg_s4  <= neg_s3;
			sat_s4  <= sat_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			last_s4 <= last_s3;
		end
	end

	// linear interpolation, round half up
	assign interp_c = $signed({2'b00, r0_s4, 23'd0}) + diff_s4 * $signed({1'b0, frac_s4})
		+ $signed(42'd4194304);

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			mag_s5  <= interp_c[39:23];
			neg_s5  <= neg_s4;
			sat_s5  <= sat_s4;
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			last_s5 <= last_s4;
		end
	end

	// sigmoid select and mirror for negative slope product
	assign spos_c = sat_s5 ? 17'd65536 : mag_s5;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			s_s6    <= neg_s5 ? (17'd65536 - spos_c) : spos_c;
			y1_s6   <= 17'(y_s5) + 17'sd256;
			x_s6    <= x_s5;
			last_s6 <= last_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			a_s7    <= x_s6 * $signed({1'b0, s_s6});
			y1_s7   <= y1_s6;
			last_s7 <= last_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			v_s8    <= a_s7 * y1_s7;
			last_s8 <= last_s7;
		end
	end

	// round to nearest, ties away from zero, then saturate
	always_comb begin
		vmag_c = v_s8[50] ? 51'(-v_s8) : 51'(v_s8);
		r_c    = 35'((vmag_c + 51'd32768) >> 16);
		if (v_s8[50]) begin
			if (r_c > 35'd2147483648)
				act_c = 32'h8000_0000;
			else
				act_c = 32'(-r_c);
		end else begin
			if (r_c > 35'd2147483647)
				act_c = 32'h7FFF_FFFF;
			else
				act_c = r_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			act_s9  <= act_c;
			last_s9 <= last_s8;
		end
	end

	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld[9];
	assign m_axis_tdata  = act_s9;
	assign m_axis_tlast  = last_s9;

endmodule
